/* rtl/dhse_pkg.sv */
// ----------------------------------------------------------------------------
// dhse_pkg
// Types, codes and fixed-point constants of the drive history speed estimator.
// ----------------------------------------------------------------------------
package dhse_pkg;

  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned SKIP_W     = 16;
  localparam int unsigned WEIGHT_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_DRIVE    = 2'd2;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [SKIP_W-1:0]   SKIP_RESET   = 16'd100;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd179;
  localparam logic [DRIVE_W-1:0]  NULL_RESET   = 16'd37356;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;

  // q = t * 100000 / 2293760 = floor(floor(t * 625 / 2^11) / 7)
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned SCALE_W     = 42;
  localparam int unsigned SCALE_MUL   = 625;
  localparam int unsigned SCALE_SHIFT = 11;
  localparam int unsigned QUOT_IN_W   = SCALE_W - SCALE_SHIFT;
  localparam int unsigned RECIP_W     = 63;
  localparam logic [31:0] RECIP7      = 32'd2454267027;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam int unsigned RAD_W       = 32;
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned SREM_W      = ROOT_W + 2;
  localparam int unsigned BLEND_W     = 24;
  localparam logic [BLEND_W-1:0] BLEND_ROUND = 24'd128;

  typedef struct packed {
    logic capture;
    logic mod_step;
    logic commit;
    logic fold_run;
    logic mul;
    logic div;
    logic sqrt_step;
    logic load_est;
    logic load_meas;
  } dhse_ctl_t;

  typedef struct packed {
    logic fill_zero;
    logic mod_done;
    logic fold_done;
    logic sqrt_done;
  } dhse_sts_t;

endpackage

/* rtl/dhse_if.sv */
// ----------------------------------------------------------------------------
// dhse_if
// Valid/ready channels of the estimator: request, result and configuration.
// ----------------------------------------------------------------------------
interface dhse_in_if;
  import dhse_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [DRIVE_W-1:0] drive_value;
  logic [SPEED_W-1:0] wheel_speed;
  modport source (output valid, cmd, drive_value, wheel_speed, input ready);
  modport sink   (input valid, cmd, drive_value, wheel_speed, output ready);
endinterface

interface dhse_out_if;
  import dhse_pkg::*;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] estimated_speed;
  logic               history_empty;
  modport source (output valid, estimated_speed, history_empty, input ready);
  modport sink   (input valid, estimated_speed, history_empty, output ready);
endinterface

interface dhse_cfg_if;
  import dhse_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/dhse_ram.sv */
// ----------------------------------------------------------------------------
// dhse_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dhse_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dhse_datapath.sv */
// ----------------------------------------------------------------------------
// dhse_datapath
// Registers, history ring, frame remainder, fold, scale and square root.
// ----------------------------------------------------------------------------
module dhse_datapath #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dhse_pkg::dhse_ctl_t           ctl_i,
  output dhse_pkg::dhse_sts_t           sts_o,
  input  logic [dhse_pkg::DRIVE_W-1:0]  drive_value_i,
  input  logic [dhse_pkg::SPEED_W-1:0]  wheel_speed_i,
  input  logic                          cfg_we_i,
  input  logic [dhse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dhse_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [dhse_pkg::SPEED_W-1:0]  estimated_speed_o,
  output logic                          history_empty_o
);
  import dhse_pkg::*;

  localparam int unsigned IdxW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned NumW  = SKIP_W + 1;
  localparam int unsigned CntW  = $clog2(NumW);

  logic [SKIP_W-1:0]   skip_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [DRIVE_W-1:0]  null_q;
  logic [SKIP_W-1:0]   frame_q;
  logic [IdxW-1:0]     head_q;
  logic [FillW-1:0]    fill_q;
  logic [IdxW-1:0]     idx_q;
  logic [FillW-1:0]    issued_q;
  logic                rd_vld_q;
  logic                first_q;

  logic [DRIVE_W-1:0]  drive_q;
  logic [SPEED_W-1:0]  meas_q;
  logic [NumW-1:0]     num_q;
  logic [SKIP_W-1:0]   rem_q;
  logic [CntW-1:0]     mod_cnt_q;
  logic [ACC_W-1:0]    acc_q;
  logic [SCALE_W-1:0]  prod_q;
  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W-1:0]   root_q;
  logic [SREM_W-1:0]   srem_q;
  logic [3:0]          sqrt_cnt_q;
  logic [SPEED_W-1:0]  est_q;
  logic                empty_q;

  logic [IdxW-1:0]     head_nxt;
  logic [IdxW-1:0]     idx_nxt;
  logic                issuing;
  logic                store;
  logic [DRIVE_W-1:0]  rd_data;
  logic [NumW-1:0]     iv;
  logic [NumW-1:0]     mod_sh;
  logic [SKIP_W-1:0]   rem_d;
  logic [ACC_W:0]      fold_sum;
  logic [ACC_W:0]      diff;
  logic                diff_pos;
  logic [SCALE_W-1:0]  prod_d;
  logic [RECIP_W-1:0]  quot_prod;
  logic [SREM_W+1:0]   sq_sh;
  logic [SREM_W+1:0]   sq_trial;
  logic [WEIGHT_W-1:0] w_hist;
  logic [WEIGHT_W-1:0] w_meas;
  logic [BLEND_W-1:0]  blend_sum;

  assign head_nxt = (head_q == IdxW'(HISTORY_DEPTH - 1)) ? '0 : IdxW'(head_q + 1'b1);
  assign idx_nxt  = (idx_q == '0) ? IdxW'(HISTORY_DEPTH - 1) : IdxW'(idx_q - 1'b1);
  assign issuing  = ctl_i.fold_run && (issued_q != fill_q);
  assign store    = ctl_i.commit && (rem_q == '0);

  assign iv     = (skip_q == '0) ? NumW'(1) : NumW'(skip_q);
  assign mod_sh = {rem_q, num_q[NumW-1]};
  assign rem_d  = (mod_sh >= iv) ? SKIP_W'(mod_sh - iv) : SKIP_W'(mod_sh);

  assign fold_sum = {1'b0, acc_q} + {1'b0, rd_data, 16'h0000};

  assign diff     = {1'b0, acc_q} - {1'b0, null_q, 16'h0000};
  assign diff_pos = !diff[ACC_W] && (diff != '0);
  assign prod_d   = SCALE_W'(diff[ACC_W-1:0]) * SCALE_W'(SCALE_MUL);
  assign quot_prod = RECIP_W'(prod_q[SCALE_W-1:SCALE_SHIFT]) * RECIP_W'(RECIP7);

  assign sq_sh    = {srem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign sq_trial = (SREM_W+2)'({root_q, 2'b01});

  assign w_hist    = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign w_meas    = WEIGHT_W'(WEIGHT_ONE - w_hist);
  assign blend_sum = BLEND_W'(w_hist) * BLEND_W'(root_q)
                   + BLEND_W'(w_meas) * BLEND_W'(meas_q) + BLEND_ROUND;

  dhse_ram #(
    .Width (DRIVE_W),
    .Depth (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (head_nxt),
    .wdata_i (drive_q),
    .re_i    (issuing),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= SKIP_RESET;
      weight_q <= WEIGHT_RESET;
      null_q   <= NULL_RESET;
      frame_q  <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      issued_q <= '0;
      rd_vld_q <= 1'b0;
      first_q  <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SKIP_INTERVAL: skip_q   <= cfg_data_i[SKIP_W-1:0];
          CFG_BLEND_WEIGHT:  weight_q <= cfg_data_i[WEIGHT_W-1:0];
          CFG_NULL_DRIVE:    null_q   <= cfg_data_i[DRIVE_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.commit) begin
        frame_q <= rem_q;
        if (store) begin
          head_q <= head_nxt;
          if (fill_q < FillW'(HISTORY_DEPTH)) begin
            fill_q <= FillW'(fill_q + 1'b1);
          end
        end
      end
      if (ctl_i.capture) begin
        idx_q    <= head_q;
        issued_q <= '0;
        rd_vld_q <= 1'b0;
        first_q  <= 1'b1;
      end else if (ctl_i.fold_run) begin
        rd_vld_q <= issuing;
        if (issuing) begin
          idx_q    <= idx_nxt;
          issued_q <= FillW'(issued_q + 1'b1);
        end
        if (rd_vld_q) begin
          first_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      drive_q   <= drive_value_i;
      meas_q    <= wheel_speed_i;
      num_q     <= NumW'(frame_q) + NumW'(1);
      rem_q     <= '0;
      mod_cnt_q <= CntW'(NumW - 1);
    end
    if (ctl_i.mod_step) begin
      num_q     <= {num_q[NumW-2:0], 1'b0};
      rem_q     <= rem_d;
      mod_cnt_q <= CntW'(mod_cnt_q - 1'b1);
    end
    if (ctl_i.fold_run && rd_vld_q) begin
      if (first_q) begin
        acc_q <= {rd_data, 16'h0000};
      end else begin
        acc_q <= fold_sum[ACC_W:1];
      end
    end
    if (ctl_i.mul) begin
      prod_q <= diff_pos ? prod_d : '0;
    end
    if (ctl_i.div) begin
      rad_q      <= RAD_W'(quot_prod[RECIP_W-1:RECIP_SHIFT]);
      root_q     <= '0;
      srem_q     <= '0;
      sqrt_cnt_q <= 4'(ROOT_W - 1);
    end
    if (ctl_i.sqrt_step) begin
      rad_q      <= {rad_q[RAD_W-3:0], 2'b00};
      sqrt_cnt_q <= 4'(sqrt_cnt_q - 1'b1);
      if (sq_sh >= sq_trial) begin
        srem_q <= SREM_W'(sq_sh - sq_trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= SREM_W'(sq_sh);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (ctl_i.load_est) begin
      est_q   <= blend_sum[BLEND_W-1:8];
      empty_q <= 1'b0;
    end
    if (ctl_i.load_meas) begin
      est_q   <= meas_q;
      empty_q <= 1'b1;
    end
  end

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.mod_done  = (mod_cnt_q == '0);
  assign sts_o.fold_done = (issued_q == fill_q) && !rd_vld_q;
  assign sts_o.sqrt_done = (sqrt_cnt_q == '0);

  assign estimated_speed_o = est_q;
  assign history_empty_o   = empty_q;

endmodule

/* rtl/dhse_ctrl.sv */
// ----------------------------------------------------------------------------
// dhse_ctrl
// Sequencer of the estimator and result valid register.
// ----------------------------------------------------------------------------
module dhse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dhse_pkg::dhse_sts_t sts_i,
  output dhse_pkg::dhse_ctl_t ctl_o
);
  import dhse_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MOD    = 9'b000000010,
    ST_COMMIT = 9'b000000100,
    ST_FOLD   = 9'b000001000,
    ST_MUL    = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_SQRT   = 9'b001000000,
    ST_BLEND  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } dhse_state_e;

  dhse_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          if (in_cmd_i == CMD_UPDATE) begin
            state_d = ST_MOD;
          end else if (sts_i.fill_zero) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_FOLD;
          end
        end
      end
      ST_MOD: begin
        ctl_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_FOLD: begin
        ctl_o.fold_run = 1'b1;
        if (sts_i.fold_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        ctl_o.div = 1'b1;
        state_d   = ST_SQRT;
      end
      ST_SQRT: begin
        ctl_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (out_free) begin
          ctl_o.load_est = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl_o.load_meas = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.load_est || ctl_o.load_meas) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/drive_history_speed_estimator_unit.sv */
// ----------------------------------------------------------------------------
// drive_history_speed_estimator_unit
// Speed estimate from a decimated drive command history and measured speed.
// ----------------------------------------------------------------------------
// One request at a time. An update runs a 17-step bit-serial remainder of the
// incremented frame counter by skip_interval, then the history write if it is
// zero. A query with n stored entries makes n reads through the single history
// read port; the last read is registered and folded into the accumulator, then
// scaling, reciprocal division by seven, a 16-step square root and the blend.
// A query on an empty history skips to the result. The result sits in an output
// register, so the next request is taken while it waits. Configuration writes
// are accepted in every cycle and belong only between requests.
// ----------------------------------------------------------------------------
module drive_history_speed_estimator_unit #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dhse_in_if.sink     in_if,
  dhse_out_if.source  out_if,
  dhse_cfg_if.sink    cfg_if
);
  import dhse_pkg::*;

  dhse_ctl_t ctl;
  dhse_sts_t sts;

  assign cfg_if.ready = 1'b1;

  dhse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_cmd_i    (in_if.cmd),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  dhse_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .drive_value_i     (in_if.drive_value),
    .wheel_speed_i     (in_if.wheel_speed),
    .cfg_we_i          (cfg_if.valid),
    .cfg_index_i       (cfg_if.index),
    .cfg_data_i        (cfg_if.data),
    .estimated_speed_o (out_if.estimated_speed),
    .history_empty_o   (out_if.history_empty)
  );

endmodule
